FILE: hw/rtl/spf_pkg.sv
`default_nettype none
package spf_pkg;

  localparam int unsigned TABLE_SIZE  = 65536;
  localparam int unsigned PRIME_SLOTS = 8192;
  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned COUNT_MAX   = 8191;

  localparam int unsigned TW = $clog2(TABLE_SIZE);
  localparam int unsigned PW = $clog2(PRIME_SLOTS);

  typedef enum logic {
    FN_BUILD = 1'b0,
    FN_QUERY = 1'b1
  } spf_func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOTBUILT = 2'd2
  } spf_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_RDI,
    S_CHK,
    S_RDP,
    S_MUL,
    S_WR,
    S_NEXT,
    S_BDONE,
    S_ONE,
    S_QRD,
    S_QPF,
    S_QDIV,
    S_QCMP,
    S_QEMIT
  } spf_state_e;

  typedef struct packed {
    spf_func_e   func;
    logic [15:0] query_value;
  } spf_in_t;

  typedef struct packed {
    logic [15:0] prime;
    logic [4:0]  exponent;
    logic        last;
    spf_status_e status;
    logic [12:0] prime_count;
  } spf_out_t;

  function automatic logic [TW-1:0] tidx(input logic [31:0] v);
    return v[TW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/spf_ram.sv
`default_nettype none
module spf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/spf_div.sv
`default_nettype none
module spf_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             done_o,
  output logic [15:0]      quotient_o
);

  logic [15:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [16:0] shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    shifted = {rem_q[15:0], quo_q[15]};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = 5'd16;
    end else if (cnt_q != 5'd0) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = shifted - {1'b0, dvs_q};
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      done_d = (cnt_q == 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

FILE: hw/rtl/spf_sieve_factorizer.sv
`default_nettype none
// Smallest-prime-factor sieve and factorizer. A build transfer clears the factor table, one
// entry per cycle, then runs a linear sieve up to the limit register, clamped to
// TABLE_SIZE - 1, all on the one read port and one write port of the factor table; it
// returns one result with the prime count. A query transfer walks the stored factors: each
// division by a prime runs on a restoring divider, and the query returns one result per
// distinct prime (at most six), the final one marked last. Errors and values below two
// return one result. One item is processed at a time; the result register lets a new item
// be accepted while a result waits.
module spf_sieve_factorizer (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire spf_pkg::spf_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output spf_pkg::spf_out_t     out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [15:0]      cfg_data_i
);
  import spf_pkg::*;

  spf_state_e   state_q, state_d;
  logic [15:0]  cfg_limit_q;
  logic [15:0]  lim_q, lim_d;
  logic [15:0]  built_lim_q, built_lim_d;
  logic         ready_q, ready_d;
  logic [PW:0]  stored_q, stored_d;
  logic [PW:0]  j_q, j_d;
  logic [TW-1:0] clr_q, clr_d;
  logic [15:0]  i_q, i_d;
  logic [15:0]  spf_q, spf_d;
  logic [15:0]  p_q, p_d;
  logic [31:0]  prod_q, prod_d;
  logic [15:0]  n_q, n_d;
  logic [4:0]   e_q, e_d;
  logic [2:0]   k_q, k_d;
  spf_status_e  st_q, st_d;
  logic         out_valid_q, out_valid_d;
  spf_out_t     out_q, out_d;

  logic          ft_we;
  logic [TW-1:0] ft_waddr, ft_raddr;
  logic [15:0]   ft_wdata, ft_rdata;
  logic          pl_we;
  logic [PW-1:0] pl_waddr, pl_raddr;
  logic [15:0]   pl_wdata, pl_rdata;
  logic          div_start, div_done;
  logic [15:0]   div_q;
  logic          free, accept, more;
  logic [15:0]   lim_new, ptmp;
  logic [12:0]   count;

  spf_ram #(.Width(16), .Depth(TABLE_SIZE)) u_factor_table (
    .clk_i, .we_i(ft_we), .waddr_i(ft_waddr), .wdata_i(ft_wdata),
    .raddr_i(ft_raddr), .rdata_o(ft_rdata)
  );

  spf_ram #(.Width(16), .Depth(PRIME_SLOTS)) u_prime_list (
    .clk_i, .we_i(pl_we), .waddr_i(pl_waddr), .wdata_i(pl_wdata),
    .raddr_i(pl_raddr), .rdata_o(pl_rdata)
  );

  spf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(n_q), .divisor_i(p_d),
    .done_o(div_done), .quotient_o(div_q)
  );

  assign free        = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign lim_new     = (32'(cfg_limit_q) > 32'(TABLE_SIZE - 1)) ?
                       16'(TABLE_SIZE - 1) : cfg_limit_q;
  assign count       = (32'(stored_q) > 32'(COUNT_MAX)) ? 13'(COUNT_MAX) : 13'(stored_q);

  always_comb begin
    state_d     = state_q;
    lim_d       = lim_q;
    built_lim_d = built_lim_q;
    ready_d     = ready_q;
    stored_d    = stored_q;
    j_d         = j_q;
    clr_d       = clr_q;
    i_d         = i_q;
    spf_d       = spf_q;
    p_d         = p_q;
    prod_d      = prod_q;
    n_d         = n_q;
    e_d         = e_q;
    k_d         = k_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ft_we       = 1'b0;
    ft_waddr    = clr_q;
    ft_wdata    = '0;
    ft_raddr    = tidx(32'(i_q));
    pl_we       = 1'b0;
    pl_waddr    = stored_q[PW-1:0];
    pl_wdata    = i_q;
    pl_raddr    = j_q[PW-1:0];
    div_start   = 1'b0;
    more        = 1'b0;
    ptmp        = ft_rdata;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.func == FN_BUILD) begin
            lim_d    = lim_new;
            clr_d    = '0;
            stored_d = '0;
            state_d  = S_CLR;
          end else if (!ready_q) begin
            st_d    = ST_NOTBUILT;
            state_d = S_ONE;
          end else if (in_data_i.query_value > built_lim_q) begin
            st_d    = ST_RANGE;
            state_d = S_ONE;
          end else if (in_data_i.query_value < 16'd2) begin
            st_d    = ST_OK;
            state_d = S_ONE;
          end else begin
            n_d     = in_data_i.query_value;
            k_d     = '0;
            state_d = S_QRD;
          end
        end
      end
      S_CLR: begin
        ft_we    = 1'b1;
        ft_waddr = clr_q;
        ft_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == TW'(TABLE_SIZE - 1)) begin
          i_d     = 16'd2;
          state_d = (lim_q < 16'd2) ? S_BDONE : S_RDI;
        end
      end
      S_RDI: begin
        ft_raddr = tidx(32'(i_q));
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (ft_rdata == 16'd0) begin
          ft_we    = 1'b1;
          ft_waddr = tidx(32'(i_q));
          ft_wdata = i_q;
          spf_d    = i_q;
          if (32'(stored_q) < 32'(PRIME_SLOTS)) begin
            pl_we    = 1'b1;
            stored_d = stored_q + 1'b1;
          end
        end else begin
          spf_d = ft_rdata;
        end
        j_d     = '0;
        state_d = S_RDP;
      end
      S_RDP: begin
        pl_raddr = j_q[PW-1:0];
        state_d  = (j_q == stored_q) ? S_NEXT : S_MUL;
      end
      S_MUL: begin
        p_d     = pl_rdata;
        prod_d  = {16'b0, pl_rdata} * {16'b0, i_q};
        state_d = S_WR;
      end
      S_WR: begin
        if (prod_q > 32'(lim_q) || p_q > spf_q) begin
          state_d = S_NEXT;
        end else begin
          ft_we    = 1'b1;
          ft_waddr = tidx(prod_q);
          ft_wdata = p_q;
          j_d      = j_q + 1'b1;
          state_d  = S_RDP;
        end
      end
      S_NEXT: begin
        if (i_q == lim_q) begin
          state_d = S_BDONE;
        end else begin
          i_d     = i_q + 16'd1;
          state_d = S_RDI;
        end
      end
      S_BDONE: begin
        if (free) begin
          out_valid_d       = 1'b1;
          out_d.prime       = '0;
          out_d.exponent    = '0;
          out_d.last        = 1'b1;
          out_d.status      = ST_OK;
          out_d.prime_count = count;
          built_lim_d       = lim_q;
          ready_d           = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_ONE: begin
        if (free) begin
          out_valid_d       = 1'b1;
          out_d.prime       = '0;
          out_d.exponent    = '0;
          out_d.last        = 1'b1;
          out_d.status      = st_q;
          out_d.prime_count = '0;
          state_d           = S_IDLE;
        end
      end
      S_QRD: begin
        ft_raddr = tidx(32'(n_q));
        state_d  = S_QPF;
      end
      S_QPF: begin
        if (ft_rdata < 16'd2 || ft_rdata > n_q) begin
          ptmp = n_q;
        end
        p_d     = ptmp;
        e_d     = '0;
        state_d = S_QDIV;
        div_start = 1'b1;
      end
      S_QDIV: begin
        if (div_done) begin
          n_d = div_q;
          e_d = e_q + 5'd1;
          ft_raddr = tidx(32'(div_q));
          state_d  = (div_q > 16'd1) ? S_QCMP : S_QEMIT;
        end
      end
      S_QCMP: begin
        if (ft_rdata == p_q) begin
          div_start = 1'b1;
          state_d   = S_QDIV;
        end else begin
          state_d = S_QEMIT;
        end
      end
      S_QEMIT: begin
        more = (n_q > 16'd1) && (32'(k_q) + 32'd1 < 32'(MAX_RESULTS));
        if (free) begin
          out_valid_d       = 1'b1;
          out_d.prime       = p_q;
          out_d.exponent    = e_q;
          out_d.last        = !more;
          out_d.status      = ST_OK;
          out_d.prime_count = '0;
          k_d               = k_q + 3'd1;
          state_d           = more ? S_QRD : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_limit_q <= 16'hFFFF;
      built_lim_q <= '0;
      ready_q     <= 1'b0;
      stored_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      built_lim_q <= built_lim_d;
      ready_q     <= ready_d;
      stored_q    <= stored_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q  <= lim_d;
    j_q    <= j_d;
    clr_q  <= clr_d;
    i_q    <= i_d;
    spf_q  <= spf_d;
    p_q    <= p_d;
    prod_q <= prod_d;
    n_q    <= n_d;
    e_q    <= e_d;
    k_q    <= k_d;
    st_q   <= st_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: hw/rtl/spf_checker.sv
`default_nettype none
module spf_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire spf_pkg::spf_out_t out_data_o,
  input wire logic              cfg_ready_o
);
  import spf_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result changed or dropped.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("Configuration port refused a transfer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.last && out_data_o.prime == 16'd0 && out_data_o.prime_count == 13'd0)
    else $error("Error result is malformed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.prime != 16'd0 |->
      out_data_o.exponent != 5'd0 && out_data_o.prime_count == 13'd0)
    else $error("Factor result is malformed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.prime == 16'd0 |-> out_data_o.last && out_data_o.exponent == 5'd0)
    else $error("Empty result is not the last one.");

endmodule

bind spf_sieve_factorizer spf_checker u_spf_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .out_data_o, .cfg_ready_o
);
`default_nettype wire
